[rtl/timestamp_event_builder_unit_assert.svh]
// ----------------------------------------------------------------------------
// timestamp event builder assertion macros
// shared property wrappers, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_EVENT_BUILDER_UNIT_ASSERT_SVH
`define TIMESTAMP_EVENT_BUILDER_UNIT_ASSERT_SVH

// property that must hold in the same cycle
`define TEB_ASSERT_NOW(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property whose consequent must hold in the next cycle
`define TEB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/teb_pkg.sv]
// ----------------------------------------------------------------------------
// teb_pkg
// types and constants shared by the timestamp event builder modules
// ----------------------------------------------------------------------------
package teb_pkg;

    localparam int STAMP_W   = 48;
    localparam int LOW_W     = 28;
    localparam int UPPER_W   = STAMP_W - LOW_W;
    localparam int WORD_W    = 32;
    localparam int VALUE_W   = 16;
    localparam int CHAN_W    = 12;
    localparam int WINDOW_W  = 16;
    localparam int GUARD_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int FLAGS_W   = 8;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [WORD_W-1:0] FILLER_WORD = 32'h5e5e5e5e;
    localparam logic [WORD_W-1:0] ALL_ONES    = 32'hffffffff;
    localparam logic [WORD_W-1:0] DATA_MASK   = 32'hc0000000;
    localparam logic [WORD_W-1:0] SYNC_MASK   = 32'hc0f00000;
    localparam logic [WORD_W-1:0] SYNC_CODE   = 32'h80400000;
    localparam logic [6:0]        SKIP_CARD   = 7'd99;
    localparam logic [2:0]        BAD_SAMPLE  = 3'b111;

    // slot_valid bit positions
    localparam int BIT_SE0 = 0;
    localparam int BIT_SE1 = 1;
    localparam int BIT_FE0 = 2;
    localparam int BIT_FE1 = 3;
    localparam int BIT_ST0 = 4;
    localparam int BIT_ST1 = 5;
    localparam int BIT_FT0 = 6;
    localparam int BIT_FT1 = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EVENT_WINDOW     = 3'd0,
        REG_WRAP_GUARD       = 3'd1,
        REG_SLOW_ENERGY_BASE = 3'd2,
        REG_FAST_ENERGY_BASE = 3'd3,
        REG_SLOW_TIME_BASE   = 3'd4,
        REG_FAST_TIME_BASE   = 3'd5
    } cfg_index_t;

    // group order matches the slot_valid bit pairs
    typedef enum logic [1:0] {
        GRP_SLOW_ENERGY = 2'd0,
        GRP_FAST_ENERGY = 2'd1,
        GRP_SLOW_TIME   = 2'd2,
        GRP_FAST_TIME   = 2'd3
    } slot_group_t;

    typedef enum logic {
        ITEM_DATA = 1'b0,
        ITEM_SYNC = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic [WINDOW_W-1:0] event_window;
        logic [GUARD_W-1:0]  wrap_guard;
        logic [CHAN_W-1:0]   slow_energy_base;
        logic [CHAN_W-1:0]   fast_energy_base;
        logic [CHAN_W-1:0]   slow_time_base;
        logic [CHAN_W-1:0]   fast_time_base;
    } cfg_t;

    typedef struct packed {
        item_kind_t         kind;
        logic [LOW_W-1:0]   low;
        logic [UPPER_W-1:0] upper;
        logic [VALUE_W-1:0] value;
        logic               low_hit;
        logic               slot_en;
        slot_group_t        group;
        logic               det;
    } item_t;

endpackage

[rtl/teb_front.sv]
// ----------------------------------------------------------------------------
// teb_front
// drops empty, filler, card 99 and unknown pairs, decodes data and sync words
// ----------------------------------------------------------------------------
module teb_front import teb_pkg::*; (
    input  cfg_t              cfg,
    input  logic              in_valid,
    input  logic              q_full,
    input  logic [WORD_W-1:0] stamp_word,
    input  logic [WORD_W-1:0] info_word,
    output logic              in_stall,
    output logic              push,
    output item_t             item
);

    logic                filler;
    logic                is_data;
    logic                is_sync;
    logic                skip_card;
    logic [CHAN_W-1:0]   chan;
    logic [CHAN_W:0]     chan_x;
    logic                se_hit;
    logic                st_hit;
    logic                fe_hit;
    logic                ft_hit;
    logic                se_det;
    logic                st_det;
    logic                fe_det;
    logic                ft_det;

    always_comb
    begin
        filler = ((stamp_word == '0) && (info_word == '0))
            || ((stamp_word == FILLER_WORD)
                && ((info_word == FILLER_WORD) || (info_word == ALL_ONES)));
        is_data   = ((info_word & DATA_MASK) == DATA_MASK);
        is_sync   = ((info_word & SYNC_MASK) == SYNC_CODE);
        chan      = info_word[16 +: CHAN_W];
        chan_x    = {1'b0, chan};
        skip_card = (chan[CHAN_W-1:5] == SKIP_CARD);

        // base + 1 kept at 13 bits so a base of all ones never aliases
        se_hit = (chan == cfg.slow_energy_base)
            || (chan_x == ({1'b0, cfg.slow_energy_base} + 13'd1));
        se_det = (chan != cfg.slow_energy_base);
        st_hit = (chan == cfg.slow_time_base)
            || (chan_x == ({1'b0, cfg.slow_time_base} + 13'd1));
        st_det = (chan != cfg.slow_time_base);
        fe_hit = (chan == cfg.fast_energy_base)
            || (chan_x == ({1'b0, cfg.fast_energy_base} + 13'd1));
        fe_det = (chan != cfg.fast_energy_base);
        ft_hit = (chan == cfg.fast_time_base)
            || (chan_x == ({1'b0, cfg.fast_time_base} + 13'd1));
        ft_det = (chan != cfg.fast_time_base);

        item.kind    = is_data ? ITEM_DATA : ITEM_SYNC;
        item.low     = stamp_word[LOW_W-1:0];
        item.upper   = info_word[UPPER_W-1:0];
        item.value   = info_word[VALUE_W-1:0];
        item.low_hit = (stamp_word[LOW_W-1:0] <= {{(LOW_W-GUARD_W){1'b0}}, cfg.wrap_guard});
        item.slot_en = 1'b0;
        item.group   = GRP_SLOW_ENERGY;
        item.det     = 1'b0;

        // priority on overlapping bases
        if (se_hit)
        begin
            item.slot_en = 1'b1;
            item.group   = GRP_SLOW_ENERGY;
            item.det     = se_det;
        end
        else if (st_hit)
        begin
            item.slot_en = 1'b1;
            item.group   = GRP_SLOW_TIME;
            item.det     = st_det;
        end
        else if (fe_hit)
        begin
            item.slot_en = 1'b1;
            item.group   = GRP_FAST_ENERGY;
            item.det     = fe_det;
        end
        else if (ft_hit)
        begin
            item.slot_en = (info_word[15:13] != BAD_SAMPLE);
            item.group   = GRP_FAST_TIME;
            item.det     = ft_det;
        end

        in_stall = q_full;
        push     = in_valid && !q_full && !filler
            && ((is_data && !skip_card) || (!is_data && is_sync));
    end

endmodule

[rtl/teb_queue.sv]
// ----------------------------------------------------------------------------
// teb_queue
// two-entry queue between the word decoder and the event logic
// ----------------------------------------------------------------------------
module teb_queue import teb_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t item_in,
    input  logic  pop,
    output logic  full,
    output logic  nonempty,
    output item_t item_out
);

    item_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_pop;

    always_comb
    begin
        nonempty    = (count_reg != '0);
        full        = (count_reg == QCNT_W'(QDEPTH));
        do_pop      = pop && nonempty;
        item_out    = slot_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

[rtl/teb_back.sv]
// ----------------------------------------------------------------------------
// teb_back
// timestamp tracking, window check, event emission and slot filling
// ----------------------------------------------------------------------------
module teb_back import teb_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [WINDOW_W-1:0] event_window,
    input  logic                q_nonempty,
    input  item_t               item,
    output logic                pop,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [FLAGS_W-1:0]  slot_valid,
    output logic [VALUE_W-1:0]  fast_energy_a,
    output logic [VALUE_W-1:0]  fast_energy_b,
    output logic [VALUE_W-1:0]  slow_energy_a,
    output logic [VALUE_W-1:0]  slow_energy_b,
    output logic [STAMP_W-1:0]  fast_stamp_a,
    output logic [STAMP_W-1:0]  fast_stamp_b,
    output logic [VALUE_W-1:0]  fast_fine_a,
    output logic [VALUE_W-1:0]  fast_fine_b,
    output logic [STAMP_W-1:0]  slow_stamp_a,
    output logic [STAMP_W-1:0]  slow_stamp_b
);

    logic [STAMP_W-1:0] cur_stamp_reg;
    logic [STAMP_W-1:0] cur_stamp_next;
    logic [STAMP_W-1:0] prev_stamp_reg;
    logic [STAMP_W-1:0] prev_stamp_next;
    logic               wrap_reg;
    logic               wrap_next;
    logic [FLAGS_W-1:0] flags_reg;
    logic [FLAGS_W-1:0] flags_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic [VALUE_W-1:0] fe_store_reg [2];
    logic [VALUE_W-1:0] se_store_reg [2];
    logic [STAMP_W-1:0] ft_stamp_reg [2];
    logic [VALUE_W-1:0] ft_fine_reg  [2];
    logic [STAMP_W-1:0] st_stamp_reg [2];

    logic [FLAGS_W-1:0] ev_flags_reg;
    logic [VALUE_W-1:0] ev_fe_reg [2];
    logic [VALUE_W-1:0] ev_se_reg [2];
    logic [STAMP_W-1:0] ev_fts_reg [2];
    logic [VALUE_W-1:0] ev_ftf_reg [2];
    logic [STAMP_W-1:0] ev_sts_reg [2];

    logic               is_data;
    logic               wrap_fix;
    logic [STAMP_W-1:0] data_stamp;
    logic [STAMP_W-1:0] gap;
    logic               close;
    logic [FLAGS_W-1:0] kept_flags;
    logic [2:0]         slot_bit;
    logic               fill;
    logic               emit;

    always_comb
    begin
        pop      = q_nonempty && (!out_valid_reg || !out_stall);
        is_data  = (item.kind == ITEM_DATA);
        wrap_fix = item.low_hit && !wrap_reg;
        if (wrap_fix)
        begin
            data_stamp = {cur_stamp_reg[STAMP_W-1:LOW_W] + 1'b1, item.low};
        end
        else
        begin
            data_stamp = {cur_stamp_reg[STAMP_W-1:LOW_W], item.low};
        end
        gap        = data_stamp - prev_stamp_reg;
        close      = !gap[STAMP_W-1]
            && (gap > {{(STAMP_W-WINDOW_W){1'b0}}, event_window});
        kept_flags = close ? '0 : flags_reg;
        slot_bit   = {item.group, item.det};
        fill       = item.slot_en && !kept_flags[slot_bit];
        emit       = pop && is_data && close;

        cur_stamp_next  = cur_stamp_reg;
        prev_stamp_next = prev_stamp_reg;
        wrap_next       = wrap_reg;
        flags_next      = flags_reg;
        if (pop && is_data)
        begin
            cur_stamp_next  = data_stamp;
            prev_stamp_next = data_stamp;
            wrap_next       = wrap_reg || wrap_fix;
            flags_next      = kept_flags;
            if (fill)
            begin
                flags_next[slot_bit] = 1'b1;
            end
        end
        else if (pop)
        begin
            cur_stamp_next = {item.upper, item.low};
            wrap_next      = 1'b0;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_stamp_reg  <= '0;
            prev_stamp_reg <= '0;
            wrap_reg       <= 1'b0;
            flags_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_stamp_reg  <= cur_stamp_next;
            prev_stamp_reg <= prev_stamp_next;
            wrap_reg       <= wrap_next;
            flags_reg      <= flags_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // slot stores
    always_ff @(posedge clk)
    begin
        if (pop && is_data && fill)
        begin
            case (item.group)
                GRP_SLOW_ENERGY: se_store_reg[item.det] <= item.value;
                GRP_FAST_ENERGY: fe_store_reg[item.det] <= item.value;
                GRP_SLOW_TIME:   st_stamp_reg[item.det] <= data_stamp;
                GRP_FAST_TIME:
                begin
                    ft_stamp_reg[item.det] <= data_stamp;
                    ft_fine_reg[item.det]  <= item.value;
                end
                default: ;
            endcase
        end
    end

    // event output register, empty slots read as zero
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ev_flags_reg  <= flags_reg;
            ev_se_reg[0]  <= flags_reg[BIT_SE0] ? se_store_reg[0] : '0;
            ev_se_reg[1]  <= flags_reg[BIT_SE1] ? se_store_reg[1] : '0;
            ev_fe_reg[0]  <= flags_reg[BIT_FE0] ? fe_store_reg[0] : '0;
            ev_fe_reg[1]  <= flags_reg[BIT_FE1] ? fe_store_reg[1] : '0;
            ev_sts_reg[0] <= flags_reg[BIT_ST0] ? st_stamp_reg[0] : '0;
            ev_sts_reg[1] <= flags_reg[BIT_ST1] ? st_stamp_reg[1] : '0;
            ev_fts_reg[0] <= flags_reg[BIT_FT0] ? ft_stamp_reg[0] : '0;
            ev_fts_reg[1] <= flags_reg[BIT_FT1] ? ft_stamp_reg[1] : '0;
            ev_ftf_reg[0] <= flags_reg[BIT_FT0] ? ft_fine_reg[0]  : '0;
            ev_ftf_reg[1] <= flags_reg[BIT_FT1] ? ft_fine_reg[1]  : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign slot_valid    = ev_flags_reg;
    assign slow_energy_a = ev_se_reg[0];
    assign slow_energy_b = ev_se_reg[1];
    assign fast_energy_a = ev_fe_reg[0];
    assign fast_energy_b = ev_fe_reg[1];
    assign slow_stamp_a  = ev_sts_reg[0];
    assign slow_stamp_b  = ev_sts_reg[1];
    assign fast_stamp_a  = ev_fts_reg[0];
    assign fast_stamp_b  = ev_fts_reg[1];
    assign fast_fine_a   = ev_ftf_reg[0];
    assign fast_fine_b   = ev_ftf_reg[1];

endmodule

[rtl/timestamp_event_builder_unit.sv]
// ----------------------------------------------------------------------------
// timestamp_event_builder_unit
// time-window event builder over readout word pairs
//
// channel   | handshake              | payload
// ----------+------------------------+-------------------------------------
// input     | in_valid / in_stall    | stamp_word, info_word
// output    | out_valid / out_stall  | slot_valid and the ten event fields
// config    | cfg_we                 | cfg_index, cfg_data
//
// one word pair per cycle while in_stall is low; the pair that closes an event
// passes the queue, then the event output register, before the event shows
// the event logic takes one queued pair per cycle unless an event waits stalled
// reset clears timestamps, slot flags and queue and loads register defaults
// out_stall holds the event logic only while an event waits; the two-entry
// queue takes at most two more transfers before in_stall rises
// ----------------------------------------------------------------------------
module timestamp_event_builder_unit import teb_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [WORD_W-1:0]    stamp_word,
    input  logic [WORD_W-1:0]    info_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [FLAGS_W-1:0]   slot_valid,
    output logic [VALUE_W-1:0]   fast_energy_a,
    output logic [VALUE_W-1:0]   fast_energy_b,
    output logic [VALUE_W-1:0]   slow_energy_a,
    output logic [VALUE_W-1:0]   slow_energy_b,
    output logic [STAMP_W-1:0]   fast_stamp_a,
    output logic [STAMP_W-1:0]   fast_stamp_b,
    output logic [VALUE_W-1:0]   fast_fine_a,
    output logic [VALUE_W-1:0]   fast_fine_b,
    output logic [STAMP_W-1:0]   slow_stamp_a,
    output logic [STAMP_W-1:0]   slow_stamp_b
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_nonempty;
    item_t front_item;
    item_t back_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_EVENT_WINDOW:     cfg_next.event_window     = cfg_data;
                REG_WRAP_GUARD:       cfg_next.wrap_guard       = cfg_data[GUARD_W-1:0];
                REG_SLOW_ENERGY_BASE: cfg_next.slow_energy_base = cfg_data[CHAN_W-1:0];
                REG_FAST_ENERGY_BASE: cfg_next.fast_energy_base = cfg_data[CHAN_W-1:0];
                REG_SLOW_TIME_BASE:   cfg_next.slow_time_base   = cfg_data[CHAN_W-1:0];
                REG_FAST_TIME_BASE:   cfg_next.fast_time_base   = cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.event_window     <= 16'd50;
            cfg_reg.wrap_guard       <= 8'd26;
            cfg_reg.slow_energy_base <= 12'd64;
            cfg_reg.fast_energy_base <= 12'd72;
            cfg_reg.slow_time_base   <= 12'd80;
            cfg_reg.fast_time_base   <= 12'd88;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    teb_front u_front (
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .q_full     (q_full),
        .stamp_word (stamp_word),
        .info_word  (info_word),
        .in_stall   (in_stall),
        .push       (push),
        .item       (front_item)
    );

    teb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .pop      (pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .item_out (back_item)
    );

    teb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .event_window  (cfg_reg.event_window),
        .q_nonempty    (q_nonempty),
        .item          (back_item),
        .pop           (pop),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .slot_valid    (slot_valid),
        .fast_energy_a (fast_energy_a),
        .fast_energy_b (fast_energy_b),
        .slow_energy_a (slow_energy_a),
        .slow_energy_b (slow_energy_b),
        .fast_stamp_a  (fast_stamp_a),
        .fast_stamp_b  (fast_stamp_b),
        .fast_fine_a   (fast_fine_a),
        .fast_fine_b   (fast_fine_b),
        .slow_stamp_a  (slow_stamp_a),
        .slow_stamp_b  (slow_stamp_b)
    );

endmodule

[rtl/teb_checker.sv]
// ----------------------------------------------------------------------------
// teb_checker
// port-level checks on the event output of the builder
// ----------------------------------------------------------------------------
`include "timestamp_event_builder_unit_assert.svh"

module teb_checker import teb_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [FLAGS_W-1:0]   slot_valid,
    input  logic [STAMP_W-1:0]   fast_stamp_a,
    input  logic [STAMP_W-1:0]   fast_stamp_b,
    input  logic [VALUE_W-1:0]   fast_fine_a,
    input  logic [VALUE_W-1:0]   fast_fine_b
);

    logic       held;
    logic [1:0] ft_zero_ok;
    logic [1:0] ft_code_ok;

    assign held          = out_valid && out_stall;
    assign ft_zero_ok[0] = slot_valid[BIT_FT0] || (fast_stamp_a == '0 && fast_fine_a == '0);
    assign ft_zero_ok[1] = slot_valid[BIT_FT1] || (fast_stamp_b == '0 && fast_fine_b == '0);
    assign ft_code_ok[0] = !slot_valid[BIT_FT0] || (fast_fine_a[15:13] != BAD_SAMPLE);
    assign ft_code_ok[1] = !slot_valid[BIT_FT1] || (fast_fine_b[15:13] != BAD_SAMPLE);

    // stalled event stays offered
    `TEB_ASSERT_NEXT(a_out_hold, held, out_valid, "event dropped under stall")

    // stalled event keeps its flags
    `TEB_ASSERT_NEXT(a_flags_hold, held, $stable(slot_valid), "flags changed under stall")

    // empty fast time slots read as zero
    `TEB_ASSERT_NOW(a_ft_zero, !out_valid || (&ft_zero_ok), "empty fast time slot not zero")

    // stored fast time never carries the dropped sample code
    `TEB_ASSERT_NOW(a_ft_sample, !out_valid || (&ft_code_ok), "fast time with dropped sample")

endmodule

bind timestamp_event_builder_unit teb_checker u_teb_checker (.*);

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// timestamp event builder testbench
// drives readout word pairs through timestamp_event_builder_unit and checks
// every emitted event against a cycle-free predictor kept in step with each
// input transfer; register settings change between drained phases, both
// sides idle and stall at random, and one phase holds the output off for
// a long stretch while input keeps coming
// ----------------------------------------------------------------------------
module testbench;
    import teb_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int STUCK_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [WORD_W-1:0] stamp;
        logic [WORD_W-1:0] info;
    } pair_t;

    typedef struct {
        logic [FLAGS_W-1:0] slot_valid;
        logic [VALUE_W-1:0] fast_energy_a;
        logic [VALUE_W-1:0] fast_energy_b;
        logic [VALUE_W-1:0] slow_energy_a;
        logic [VALUE_W-1:0] slow_energy_b;
        logic [STAMP_W-1:0] fast_stamp_a;
        logic [STAMP_W-1:0] fast_stamp_b;
        logic [VALUE_W-1:0] fast_fine_a;
        logic [VALUE_W-1:0] fast_fine_b;
        logic [STAMP_W-1:0] slow_stamp_a;
        logic [STAMP_W-1:0] slow_stamp_b;
    } built_event_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    cfg_index_t           cfg_index = REG_EVENT_WINDOW;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [WORD_W-1:0]    stamp_word = '0;
    logic [WORD_W-1:0]    info_word = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [FLAGS_W-1:0]   slot_valid;
    logic [VALUE_W-1:0]   fast_energy_a;
    logic [VALUE_W-1:0]   fast_energy_b;
    logic [VALUE_W-1:0]   slow_energy_a;
    logic [VALUE_W-1:0]   slow_energy_b;
    logic [STAMP_W-1:0]   fast_stamp_a;
    logic [STAMP_W-1:0]   fast_stamp_b;
    logic [VALUE_W-1:0]   fast_fine_a;
    logic [VALUE_W-1:0]   fast_fine_b;
    logic [STAMP_W-1:0]   slow_stamp_a;
    logic [STAMP_W-1:0]   slow_stamp_b;

    // predictor state
    cfg_t               model_cfg;
    logic [STAMP_W-1:0] cur_stamp = '0;
    logic [STAMP_W-1:0] last_data_stamp = '0;
    logic               wrap_used = 1'b0;
    logic [FLAGS_W-1:0] slot_bits = '0;
    logic [VALUE_W-1:0] se_val [2];
    logic [VALUE_W-1:0] fe_val [2];
    logic [VALUE_W-1:0] ff_val [2];
    logic [STAMP_W-1:0] fs_val [2];
    logic [STAMP_W-1:0] ss_val [2];

    pair_t        word_pairs [$];
    built_event_t closed_events [$];
    pair_t        next_pair;
    built_event_t oldest_event;

    // stimulus and handshake state
    logic [LOW_W-1:0]   gen_low = '0;
    logic [UPPER_W-1:0] gen_upper = '0;
    int  burst_left = 0;
    int  gap_left = 0;
    bit  steady_send = 1'b0;
    int  stall_pct = 30;
    int  stall_run = 0;
    int  hold_left = 0;
    int  hold_reqs = 0;
    int  hold_done = 0;
    int  stuck_cycles = 0;
    int  mismatches = 0;
    int  pairs_sent = 0;
    int  events_checked = 0;
    int  settings_used = 1;

    timestamp_event_builder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .stamp_word    (stamp_word),
        .info_word     (info_word),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .slot_valid    (slot_valid),
        .fast_energy_a (fast_energy_a),
        .fast_energy_b (fast_energy_b),
        .slow_energy_a (slow_energy_a),
        .slow_energy_b (slow_energy_b),
        .fast_stamp_a  (fast_stamp_a),
        .fast_stamp_b  (fast_stamp_b),
        .fast_fine_a   (fast_fine_a),
        .fast_fine_b   (fast_fine_b),
        .slow_stamp_a  (slow_stamp_a),
        .slow_stamp_b  (slow_stamp_b)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int det_of(input logic [CHAN_W-1:0] chan,
                                  input logic [CHAN_W-1:0] base);
        if (chan == base)
            return 0;
        if ({1'b0, chan} == {1'b0, base} + 13'd1)
            return 1;
        return -1;
    endfunction

    function automatic logic [WORD_W-1:0] data_word(input logic [CHAN_W-1:0] chan,
                                                    input logic [VALUE_W-1:0] val);
        return {2'b11, 2'b00, chan, val};
    endfunction

    function automatic logic [WORD_W-1:0] sync_word(input logic [UPPER_W-1:0] upper);
        return {2'b10, 6'd0, 4'b0100, upper};
    endfunction

    task automatic clear_slots();
        slot_bits = '0;
        for (int i = 0; i < 2; i++)
        begin
            se_val[i] = '0;
            fe_val[i] = '0;
            ff_val[i] = '0;
            fs_val[i] = '0;
            ss_val[i] = '0;
        end
    endtask

    // advances the predictor by one word pair, queues the event it closes
    task automatic build_pair(input logic [WORD_W-1:0] stamp, input logic [WORD_W-1:0] info);
        logic [LOW_W-1:0]   low;
        logic [CHAN_W-1:0]  chan;
        logic [VALUE_W-1:0] val;
        logic [STAMP_W-1:0] gap;
        built_event_t       ev;
        int                 d;
        low = stamp[LOW_W-1:0];
        chan = info[27:16];
        val = info[VALUE_W-1:0];
        if (stamp == '0 && info == '0)
            return;
        if (stamp == FILLER_WORD && (info == FILLER_WORD || info == ALL_ONES))
            return;
        if ((info & DATA_MASK) == DATA_MASK)
        begin
            if (chan[CHAN_W-1:5] == SKIP_CARD)
                return;
            cur_stamp = {cur_stamp[STAMP_W-1:LOW_W], low};
            if (low <= model_cfg.wrap_guard && !wrap_used)
            begin
                cur_stamp = cur_stamp + (48'd1 << LOW_W);
                wrap_used = 1'b1;
            end
            gap = cur_stamp - last_data_stamp;
            if (!gap[STAMP_W-1] && gap > model_cfg.event_window)
            begin
                ev.slot_valid    = slot_bits;
                ev.fast_energy_a = slot_bits[BIT_FE0] ? fe_val[0] : '0;
                ev.fast_energy_b = slot_bits[BIT_FE1] ? fe_val[1] : '0;
                ev.slow_energy_a = slot_bits[BIT_SE0] ? se_val[0] : '0;
                ev.slow_energy_b = slot_bits[BIT_SE1] ? se_val[1] : '0;
                ev.fast_stamp_a  = slot_bits[BIT_FT0] ? fs_val[0] : '0;
                ev.fast_stamp_b  = slot_bits[BIT_FT1] ? fs_val[1] : '0;
                ev.fast_fine_a   = slot_bits[BIT_FT0] ? ff_val[0] : '0;
                ev.fast_fine_b   = slot_bits[BIT_FT1] ? ff_val[1] : '0;
                ev.slow_stamp_a  = slot_bits[BIT_ST0] ? ss_val[0] : '0;
                ev.slow_stamp_b  = slot_bits[BIT_ST1] ? ss_val[1] : '0;
                closed_events.push_back(ev);
                clear_slots();
            end
            // priority: slow energy, slow time, fast energy, fast time
            d = det_of(chan, model_cfg.slow_energy_base);
            if (d >= 0)
            begin
                if (!slot_bits[BIT_SE0 + d])
                begin
                    se_val[d] = val;
                    slot_bits[BIT_SE0 + d] = 1'b1;
                end
            end
            else
            begin
                d = det_of(chan, model_cfg.slow_time_base);
                if (d >= 0)
                begin
                    if (!slot_bits[BIT_ST0 + d])
                    begin
                        ss_val[d] = cur_stamp;
                        slot_bits[BIT_ST0 + d] = 1'b1;
                    end
                end
                else
                begin
                    d = det_of(chan, model_cfg.fast_energy_base);
                    if (d >= 0)
                    begin
                        if (!slot_bits[BIT_FE0 + d])
                        begin
                            fe_val[d] = val;
                            slot_bits[BIT_FE0 + d] = 1'b1;
                        end
                    end
                    else
                    begin
                        d = det_of(chan, model_cfg.fast_time_base);
                        if (d >= 0 && val[15:13] != BAD_SAMPLE && !slot_bits[BIT_FT0 + d])
                        begin
                            fs_val[d] = cur_stamp;
                            ff_val[d] = val;
                            slot_bits[BIT_FT0 + d] = 1'b1;
                        end
                    end
                end
            end
            last_data_stamp = cur_stamp;
        end
        else if ((info & SYNC_MASK) == SYNC_CODE)
        begin
            cur_stamp = {info[UPPER_W-1:0], low};
            wrap_used = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [STAMP_W-1:0] want,
                               input logic [STAMP_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %h, got %h", name, want, got);
        end
    endtask

    task automatic push_pair(input logic [WORD_W-1:0] stamp, input logic [WORD_W-1:0] info);
        pair_t p;
        p.stamp = stamp;
        p.info = info;
        word_pairs.push_back(p);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DAT_W'(value);
        case (idx)
            REG_EVENT_WINDOW:     model_cfg.event_window = WINDOW_W'(value);
            REG_WRAP_GUARD:       model_cfg.wrap_guard = GUARD_W'(value);
            REG_SLOW_ENERGY_BASE: model_cfg.slow_energy_base = CHAN_W'(value);
            REG_FAST_ENERGY_BASE: model_cfg.fast_energy_base = CHAN_W'(value);
            REG_SLOW_TIME_BASE:   model_cfg.slow_time_base = CHAN_W'(value);
            REG_FAST_TIME_BASE:   model_cfg.fast_time_base = CHAN_W'(value);
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_config(input int window, input int guard, input int se, input int fe,
                               input int st, input int ft);
        write_reg(REG_EVENT_WINDOW, window);
        write_reg(REG_WRAP_GUARD, guard);
        write_reg(REG_SLOW_ENERGY_BASE, se);
        write_reg(REG_FAST_ENERGY_BASE, fe);
        write_reg(REG_SLOW_TIME_BASE, st);
        write_reg(REG_FAST_TIME_BASE, ft);
        settings_used++;
    endtask

    // wait until every pair is through and every event has come out
    task automatic settle();
        while (word_pairs.size() != 0 || in_valid || closed_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly well-formed data and sync words on an advancing stamp
    task automatic queue_random(input int n);
        int                made;
        int                pick;
        int                r;
        int                w;
        logic [WORD_W-1:0] stamp;
        logic [WORD_W-1:0] info;
        logic [CHAN_W-1:0] chan;
        made = 0;
        w = int'(model_cfg.event_window);
        while (made < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                gen_low = gen_low + LOW_W'($urandom_range(0, w / 2 + 1));
            else if (r < 85)
                gen_low = gen_low + LOW_W'($urandom_range(w + 1, w + 300));
            else if (r < 92)
                gen_low = gen_low - LOW_W'($urandom_range(1, w + 100));
            else if (r < 97)
                gen_low = LOW_W'($urandom_range(0, model_cfg.wrap_guard + 4));
            else
                gen_low = LOW_W'($urandom);
            stamp = {4'($urandom), gen_low};
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                r = $urandom_range(0, 99);
                case ($urandom_range(0, 3))
                    0: chan = model_cfg.slow_energy_base;
                    1: chan = model_cfg.fast_energy_base;
                    2: chan = model_cfg.slow_time_base;
                    default: chan = model_cfg.fast_time_base;
                endcase
                if (r < 85)
                    chan = chan + CHAN_W'($urandom_range(0, 1));
                else if (r < 90)
                    chan = {SKIP_CARD, 5'($urandom)};
                else
                    chan = CHAN_W'($urandom);
                info = {2'b11, 2'($urandom), chan, 16'($urandom)};
            end
            else if (pick < 78)
            begin
                if ($urandom_range(0, 9) < 3)
                    gen_upper = UPPER_W'($urandom);
                else
                    gen_upper = gen_upper + UPPER_W'($urandom_range(0, 1));
                info = {2'b10, 6'($urandom), 4'b0100, gen_upper};
            end
            else if (pick < 85)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        stamp = '0;
                        info = '0;
                    end
                    1:
                    begin
                        stamp = FILLER_WORD;
                        info = FILLER_WORD;
                    end
                    default:
                    begin
                        stamp = FILLER_WORD;
                        info = ALL_ONES;
                    end
                endcase
            end
            else if (pick < 90)
            begin
                info = $urandom;
                info[31:30] = 2'($urandom_range(0, 2));
                if (info[31:30] == 2'b10 && info[23:20] == 4'b0100)
                    info[20] = 1'b1;
            end
            else
            begin
                stamp = $urandom;
                info = $urandom;
            end
            push_pair(stamp, info);
            made++;
        end
    endtask

    task automatic queue_directed();
        push_pair(32'h0000_0000, 32'h0000_0000);
        push_pair(FILLER_WORD, FILLER_WORD);
        push_pair(FILLER_WORD, ALL_ONES);
        push_pair(32'h0000_0100, sync_word(20'h12345));
        // closes an event with no slot filled
        push_pair(32'h0000_1000, data_word(12'd64, 16'h1111));
        push_pair(32'h0000_1010, data_word(12'd65, 16'hffff));
        push_pair(32'h0000_1010, data_word(12'd72, 16'h0000));
        push_pair(32'h0000_1011, data_word(12'd73, 16'h8001));
        push_pair(32'h0000_1012, data_word(12'd80, 16'h1234));
        push_pair(32'h0000_1013, data_word(12'd81, 16'h4321));
        push_pair(32'h0000_1014, data_word(12'd88, 16'h1fff));
        // fast time with sample 7 is dropped
        push_pair(32'h0000_1015, data_word(12'd89, 16'he000));
        push_pair(32'h0000_1016, data_word(12'd89, 16'hdfff));
        // slot already taken
        push_pair(32'h0000_1017, data_word(12'd64, 16'h2222));
        // skipped card
        push_pair(32'h0000_9000, data_word(12'd3168, 16'h5555));
        push_pair(32'h0000_2000, data_word(12'd64, 16'h3333));
        push_pair(32'h0000_2000, 32'h4000_0000);
        // wrap correction carries past the top of the 48-bit stamp
        push_pair(32'h0000_0000, sync_word(20'hfffff));
        push_pair(32'h0000_0005, data_word(12'd88, 16'h0001));
        push_pair(32'h0000_0003, data_word(12'd80, 16'h0002));
        push_pair(32'hffff_ffff, data_word(12'd72, 16'hffff));
        push_pair(32'h1234_5678, ALL_ONES);
        push_pair(32'h0000_0000, data_word(12'd0, 16'h0000));
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                build_pair(stamp_word, info_word);
                pairs_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (word_pairs.size() != 0)
                begin
                    next_pair = word_pairs.pop_front();
                    in_valid <= 1'b1;
                    stamp_word <= next_pair.stamp;
                    info_word <= next_pair.info;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = steady_send ? 0 : $urandom_range(0, 12);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each event transfer and stalls on runs of its own
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (closed_events.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("event with none expected, slot_valid %h", slot_valid);
                end
                else
                begin
                    oldest_event = closed_events.pop_front();
                    check_field("slot_valid", STAMP_W'(oldest_event.slot_valid),
                                STAMP_W'(slot_valid));
                    check_field("fast_energy_a", STAMP_W'(oldest_event.fast_energy_a),
                                STAMP_W'(fast_energy_a));
                    check_field("fast_energy_b", STAMP_W'(oldest_event.fast_energy_b),
                                STAMP_W'(fast_energy_b));
                    check_field("slow_energy_a", STAMP_W'(oldest_event.slow_energy_a),
                                STAMP_W'(slow_energy_a));
                    check_field("slow_energy_b", STAMP_W'(oldest_event.slow_energy_b),
                                STAMP_W'(slow_energy_b));
                    check_field("fast_stamp_a", oldest_event.fast_stamp_a, fast_stamp_a);
                    check_field("fast_stamp_b", oldest_event.fast_stamp_b, fast_stamp_b);
                    check_field("fast_fine_a", STAMP_W'(oldest_event.fast_fine_a),
                                STAMP_W'(fast_fine_a));
                    check_field("fast_fine_b", STAMP_W'(oldest_event.fast_fine_b),
                                STAMP_W'(fast_fine_b));
                    check_field("slow_stamp_a", oldest_event.slow_stamp_a, slow_stamp_a);
                    check_field("slow_stamp_b", oldest_event.slow_stamp_b, slow_stamp_b);
                    events_checked++;
                end
            end
            if (hold_done != hold_reqs)
            begin
                hold_done = hold_reqs;
                hold_left = HOLD_CYCLES;
                stall_run = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_run > 0)
            begin
                stall_run--;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                stall_run = $urandom_range(0, 7);
                out_stall <= 1'b1;
            end
            else
            begin
                stall_run = $urandom_range(0, 15);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog: cycles with work outstanding and no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n && (in_valid || word_pairs.size() != 0 || closed_events.size() != 0)
            && !(in_valid && !in_stall) && !(out_valid && !out_stall))
        begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", stuck_cycles);
                $display("testbench: errors");
                $finish;
            end
        end
        else
        begin
            stuck_cycles = 0;
        end
    end

    initial
    begin
        model_cfg.event_window = 16'd50;
        model_cfg.wrap_guard = 8'd26;
        model_cfg.slow_energy_base = 12'd64;
        model_cfg.fast_energy_base = 12'd72;
        model_cfg.slow_time_base = 12'd80;
        model_cfg.fast_time_base = 12'd88;
        clear_slots();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        queue_directed();
        settle();
        queue_random(200);
        settle();

        stall_pct = 0;
        load_config(0, 0, 0, 0, 0, 0);
        queue_random(200);
        settle();

        stall_pct = 40;
        load_config(65535, 255, 4094, 4094, 4094, 4094);
        queue_random(200);
        settle();

        // output held off while the sender keeps going
        stall_pct = 20;
        load_config(50, 26, 64, 72, 80, 88);
        steady_send = 1'b1;
        hold_reqs++;
        queue_random(250);
        settle();
        steady_send = 1'b0;

        for (int phase = 0; phase < 5; phase++)
        begin
            stall_pct = $urandom_range(0, 70);
            steady_send = ($urandom_range(0, 3) == 0);
            if (phase == 4)
                load_config($urandom_range(0, 65535), $urandom_range(0, 255),
                            $urandom_range(0, 4094), $urandom_range(0, 4094),
                            $urandom_range(0, 4094), $urandom_range(0, 4094));
            else
                load_config($urandom_range(0, 300), $urandom_range(0, 255),
                            $urandom_range(100, 106), $urandom_range(100, 106),
                            $urandom_range(100, 106), $urandom_range(100, 106));
            queue_random(200);
            settle();
        end

        settle();
        $display("summary: %0d word pairs sent, %0d events checked, %0d register settings",
                 pairs_sent, events_checked, settings_used);
        $display("summary: fillers, sync, wrap, channel overlap and long output hold-off run");
        if (mismatches == 0 && closed_events.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
